>>> hdl/ists_pkg.sv
// ists_pkg: shared constants, state codes and control structs
// for the integer set span tracker; no dependencies
package ists_pkg;

   localparam int DEPTH    = 64;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int COUNT_W  = 7;
   localparam int VALUE_W  = 32;
   localparam int GAP_W    = VALUE_W + 1;

   localparam logic [COUNT_W-1:0] DEPTH_COUNT  = COUNT_W'(DEPTH);
   localparam logic [COUNT_W-1:0] CAP_RESET    = 7'd64;
   localparam logic [VALUE_W-1:0] SIGN_BIAS    = 32'h8000_0000;
   localparam logic [GAP_W-1:0]   GAP_NONE     = {GAP_W{1'b1}};

   localparam logic STATUS_STORED   = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_GAPS   = 5'b00100,
      S_COMMIT = 5'b01000,
      S_REPORT = 5'b10000
   } state_type;

   typedef struct packed {
      logic               clear;
      logic               data_valid;
      logic [VALUE_W-1:0] key;
   } scan_ctl_type;

   typedef struct packed {
      logic               have_below;
      logic [VALUE_W-1:0] below;
      logic               have_above;
      logic [VALUE_W-1:0] above;
   } scan_res_type;

   function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] raw);
      return raw ^ SIGN_BIAS;
   endfunction

endpackage

>>> hdl/integer_set_span_tracker_top.sv
// integer_set_span_tracker_top: control sequencer, span registers and ports
// depends on ists_pkg, ists_store, ists_scan
//
// A word offered on req_value is taken when start is high and busy is low.
// Exactly one response word follows per request, shown for one cycle with
// rsp_strobe; the receiver cannot stall it, so it must take every strobe.
// A stored word takes one store read per held entry (held = count before
// the insert) during the neighbor scan, then the gap, commit and report
// states; the next request can be taken in the strobe cycle. A rejected
// word skips the scan and goes straight from idle to the report state. The
// capacity register is written through csr_write_enable/csr_write_data
// and should change only while the block is idle.
module integer_set_span_tracker_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_strobe,
   output logic                          rsp_status,
   output logic [6:0]                    rsp_held,
   output logic                          rsp_spans_valid,
   output logic [31:0]                   rsp_shortest_span,
   output logic [31:0]                   rsp_longest_span,
   input  logic                          csr_write_enable,
   input  logic [6:0]                    csr_write_data
);
   import ists_pkg::*;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  capacity_ff;
   logic [COUNT_W-1:0]  addr_ff, addr_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [VALUE_W-1:0]  small_ff, small_in;
   logic [VALUE_W-1:0]  large_ff, large_in;
   logic [GAP_W-1:0]    gap_ff, gap_in;
   logic                status_ff, status_in;
   logic                rd_vld_ff;
   logic                have_below_ff, have_above_ff;
   logic [VALUE_W-1:0]  gap_below_ff, gap_above_ff;
   logic                rsp_strobe_ff;
   logic                rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_held_ff;
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rsp_short_ff;
   logic [VALUE_W-1:0]  rsp_long_ff;

   logic [COUNT_W-1:0]  limit;
   logic                full;
   logic [VALUE_W-1:0]  kv;
   logic                rd_en;
   logic                wr_en;
   logic                rsp_load;
   logic                near_ok;
   logic [VALUE_W-1:0]  near;
   logic                spans_ok;
   logic [VALUE_W-1:0]  rd_data;
   scan_ctl_type        scan_ctl;
   scan_res_type        scan_res;

   ists_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (addr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   ists_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .rd_data (rd_data),
      .res     (scan_res)
   );

   assign limit = (capacity_ff < DEPTH_COUNT) ? capacity_ff : DEPTH_COUNT;
   assign full  = (count_ff >= limit);
   assign kv    = order_key(value_ff);

   always_comb begin
      near_ok = have_below_ff | have_above_ff;
      if (have_below_ff && have_above_ff) begin
         near = (gap_below_ff < gap_above_ff) ? gap_below_ff : gap_above_ff;
      end else if (have_below_ff) begin
         near = gap_below_ff;
      end else begin
         near = gap_above_ff;
      end
   end

   always_comb begin
      state_in            = state_ff;
      count_in            = count_ff;
      addr_in             = addr_ff;
      value_in            = value_ff;
      small_in            = small_ff;
      large_in            = large_ff;
      gap_in              = gap_ff;
      status_in           = status_ff;
      rd_en               = 1'b0;
      wr_en               = 1'b0;
      rsp_load            = 1'b0;
      scan_ctl.clear      = 1'b0;
      scan_ctl.data_valid = rd_vld_ff;
      scan_ctl.key        = kv;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               value_in = VALUE_W'(req_value);
               addr_in  = '0;
               if (full) begin
                  status_in = STATUS_REJECTED;
                  state_in  = S_REPORT;
               end else begin
                  status_in      = STATUS_STORED;
                  scan_ctl.clear = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (addr_ff < count_ff) begin
               rd_en   = 1'b1;
               addr_in = addr_ff + 1'b1;
            end else begin
               state_in = S_GAPS;
            end
         end
         S_GAPS: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (near_ok && {1'b0, near} < gap_ff) begin
               gap_in = {1'b0, near};
            end
            if (count_ff == '0) begin
               small_in = value_ff;
               large_in = value_ff;
            end else begin
               if (kv < order_key(small_ff)) begin
                  small_in = value_ff;
               end
               if (kv > order_key(large_ff)) begin
                  large_in = value_ff;
               end
            end
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = S_REPORT;
         end
         S_REPORT: begin
            rsp_load = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign spans_ok = (count_ff >= COUNT_W'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         capacity_ff   <= CAP_RESET;
         small_ff      <= '0;
         large_ff      <= '0;
         gap_ff        <= GAP_NONE;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         small_ff      <= small_in;
         large_ff      <= large_in;
         gap_ff        <= gap_in;
         rd_vld_ff     <= rd_en;
         rsp_strobe_ff <= rsp_load;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
      end
      addr_ff       <= addr_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      have_below_ff <= scan_res.have_below;
      have_above_ff <= scan_res.have_above;
      gap_below_ff  <= kv - scan_res.below;
      gap_above_ff  <= scan_res.above - kv;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_held_ff   <= count_ff;
         rsp_valid_ff  <= spans_ok;
         rsp_short_ff  <= spans_ok ? gap_ff[VALUE_W-1:0] : '0;
         rsp_long_ff   <= spans_ok ? (order_key(large_ff) - order_key(small_ff)) : '0;
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_held          = rsp_held_ff;
   assign rsp_spans_valid   = rsp_valid_ff;
   assign rsp_shortest_span = rsp_short_ff;
   assign rsp_longest_span  = rsp_long_ff;

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < DEPTH_COUNT))
      else $error("store write past depth");

   a_commit_reports: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT) |=> ##1 (rsp_strobe && rsp_status == STATUS_STORED
                                      && rsp_held == count_ff))
      else $error("commit not followed by stored response");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_spans_valid) |->
         (rsp_shortest_span == '0 && rsp_longest_span == '0))
      else $error("spans nonzero while invalid");

   a_reject_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start && full) |=> (state_ff == S_REPORT && !wr_en
                                                 && $stable(count_ff)))
      else $error("rejected word changed the store");

endmodule

>>> hdl/ists_store.sv
// ists_store: single-port-write, single-port-read number memory,
// registered read data; uses ists_pkg
module ists_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ists_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [ists_pkg::VALUE_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [ists_pkg::ADDR_W-1:0]   rd_addr,
   output logic [ists_pkg::VALUE_W-1:0]  rd_data
);
   import ists_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ists_scan.sv
// ists_scan: nearest smaller-or-equal and larger-or-equal neighbor search,
// one stored word per cycle; uses ists_pkg
module ists_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  ists_pkg::scan_ctl_type        ctl,
   input  logic [ists_pkg::VALUE_W-1:0]  rd_data,
   output ists_pkg::scan_res_type        res
);
   import ists_pkg::*;

   logic               have_below_ff, have_below_in;
   logic               have_above_ff, have_above_in;
   logic [VALUE_W-1:0] below_ff, below_in;
   logic [VALUE_W-1:0] above_ff, above_in;
   logic [VALUE_W-1:0] k;

   always_comb begin
      k             = order_key(rd_data);
      have_below_in = have_below_ff;
      have_above_in = have_above_ff;
      below_in      = below_ff;
      above_in      = above_ff;
      if (ctl.clear) begin
         have_below_in = 1'b0;
         have_above_in = 1'b0;
      end else if (ctl.data_valid) begin
         if (k <= ctl.key && (!have_below_ff || k > below_ff)) begin
            have_below_in = 1'b1;
            below_in      = k;
         end
         if (k >= ctl.key && (!have_above_ff || k < above_ff)) begin
            have_above_in = 1'b1;
            above_in      = k;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_below_ff <= 1'b0;
         have_above_ff <= 1'b0;
      end else begin
         have_below_ff <= have_below_in;
         have_above_ff <= have_above_in;
      end
      below_ff <= below_in;
      above_ff <= above_in;
   end

   assign res.have_below = have_below_ff;
   assign res.below      = below_ff;
   assign res.have_above = have_above_ff;
   assign res.above      = above_ff;

endmodule

>>> dv/span_check_pkg.sv
// span_check_pkg: scoreboard class for the integer set span tracker bench,
// with its own copy of the held numbers, spans and capacity
// depends on ists_pkg for widths, depth and status codes
package span_check_pkg;
   import ists_pkg::*;

   class span_scoreboard;
      typedef struct {
         logic               status;
         logic [COUNT_W-1:0] held;
         logic               valid;
         logic [VALUE_W-1:0] shortest;
         logic [VALUE_W-1:0] longest;
      } span_word_type;

      logic [VALUE_W-1:0] numbers [DEPTH];
      int unsigned        count;
      logic [VALUE_W-1:0] smallest;
      logic [VALUE_W-1:0] largest;
      logic [GAP_W-1:0]   least_gap;
      logic [COUNT_W-1:0] capacity;
      span_word_type      expected_spans [$];
      int unsigned        errors;
      int unsigned        stored;
      int unsigned        rejected;
      int unsigned        checked;

      function void reset_state();
         count     = 0;
         smallest  = '0;
         largest   = '0;
         least_gap = GAP_NONE;
         capacity  = CAP_RESET;
         expected_spans.delete();
      endfunction

      function int unsigned pending();
         return expected_spans.size();
      endfunction

      function logic [VALUE_W-1:0] random_held();
         return numbers[$urandom_range(count - 1)];
      endfunction

      // one accepted request word: insert or reject, then the spans it reports
      function void note_value(logic [VALUE_W-1:0] value);
         logic [VALUE_W-1:0] key;
         logic [VALUE_W-1:0] k;
         logic [VALUE_W-1:0] below;
         logic [VALUE_W-1:0] above;
         logic               have_below;
         logic               have_above;
         logic               full;
         int unsigned        limit;
         span_word_type      w;
         key   = value ^ SIGN_BIAS;
         limit = (capacity < DEPTH) ? capacity : DEPTH;
         full  = (count >= limit);
         if (!full) begin
            have_below = 1'b0;
            have_above = 1'b0;
            below      = '0;
            above      = '0;
            for (int i = 0; i < count; i++) begin
               k = numbers[i] ^ SIGN_BIAS;
               if (k <= key && (!have_below || k > below)) begin
                  below      = k;
                  have_below = 1'b1;
               end
               if (k >= key && (!have_above || k < above)) begin
                  above      = k;
                  have_above = 1'b1;
               end
            end
            if (have_below && {1'b0, key - below} < least_gap)
               least_gap = {1'b0, key - below};
            if (have_above && {1'b0, above - key} < least_gap)
               least_gap = {1'b0, above - key};
            if (count == 0) begin
               smallest = value;
               largest  = value;
            end else begin
               if (key < (smallest ^ SIGN_BIAS))
                  smallest = value;
               if (key > (largest ^ SIGN_BIAS))
                  largest = value;
            end
            numbers[count] = value;
            count++;
            stored++;
         end else begin
            rejected++;
         end
         w.status   = full ? STATUS_REJECTED : STATUS_STORED;
         w.held     = COUNT_W'(count);
         w.valid    = (count >= 2);
         w.shortest = w.valid ? least_gap[VALUE_W-1:0] : '0;
         w.longest  = w.valid ? ((largest ^ SIGN_BIAS) - (smallest ^ SIGN_BIAS)) : '0;
         expected_spans = {expected_spans, w};
      endfunction

      function void check_word(logic status, logic [COUNT_W-1:0] held, logic valid,
                                logic [VALUE_W-1:0] shortest, logic [VALUE_W-1:0] longest);
         span_word_type w;
         if (expected_spans.size() == 0) begin
            $error("response word with no request outstanding");
            errors++;
            return;
         end
         w = expected_spans.pop_front();
         checked++;
         if (status !== w.status) begin
            $error("status expected %0h actual %0h", w.status, status);
            errors++;
         end
         if (held !== w.held) begin
            $error("held expected %0d actual %0d", w.held, held);
            errors++;
         end
         if (valid !== w.valid) begin
            $error("spans_valid expected %0h actual %0h", w.valid, valid);
            errors++;
         end
         if (shortest !== w.shortest) begin
            $error("shortest_span expected %0h actual %0h", w.shortest, shortest);
            errors++;
         end
         if (longest !== w.longest) begin
            $error("longest_span expected %0h actual %0h", w.longest, longest);
            errors++;
         end
      endfunction
   endclass

endpackage

>>> dv/tb.sv
// tb: self-checking bench for integer_set_span_tracker_top, directed words
// then random phases over capacity settings and request idling
// depends on ists_pkg, span_check_pkg and the tracker RTL
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ists_pkg::*;
   import span_check_pkg::*;

   localparam int PHASE_WORDS = 85;
   localparam int PHASE_CAP [8] = '{12, 4, 24, 0, 40, 127, 50, 64};
   localparam int PHASE_IDLE [4] = '{0, 86, 0, 28};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic signed [31:0]  req_value = '0;
   logic                csr_write_enable = 1'b0;
   logic [6:0]          csr_write_data = '0;
   logic                busy;
   logic                rsp_strobe;
   logic                rsp_status;
   logic [6:0]          rsp_held;
   logic                rsp_spans_valid;
   logic [31:0]         rsp_shortest_span;
   logic [31:0]         rsp_longest_span;

   span_scoreboard sb = new;
   int             idle_pct = 0;
   int unsigned    cfg_writes = 0;

   always #6 clock = ~clock;

   integer_set_span_tracker_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_value         (req_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_held          (rsp_held),
      .rsp_spans_valid   (rsp_spans_valid),
      .rsp_shortest_span (rsp_shortest_span),
      .rsp_longest_span  (rsp_longest_span),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_value(req_value);
      if (!reset && rsp_strobe)
         sb.check_word(rsp_status, rsp_held, rsp_spans_valid,
                       rsp_shortest_span, rsp_longest_span);
   end

   initial begin
      #20_000_000;
      $display("integer_set_span_tracker_top regression: fail");
      $finish;
   end

   task automatic send_value(input logic [31:0] value);
      int gap;
      gap = 0;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct)
         gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [6:0] cap);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.capacity = cap;
      cfg_writes++;
   endtask

   // mix of extremes, duplicates, near neighbors and wide random numbers
   function automatic logic [31:0] pick_value();
      logic [31:0] offset;
      offset = 32'($urandom_range(32)) - 32'd16;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
         1, 2: return (sb.count != 0) ? sb.random_held() : $urandom;
         3, 4, 5: return (sb.count != 0) ? sb.random_held() + offset : offset;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int wait_cycles;
      sb.reset_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero capacity rejects everything
      write_capacity(7'd0);
      send_value(32'h0000_0000);
      send_value(32'h8000_0000);
      send_value(32'hFFFF_FFFF);
      // single entry, then store full
      write_capacity(7'd1);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      // full range span, duplicates, neighbors of zero
      write_capacity(7'd6);
      send_value(32'h7FFF_FFFF);
      send_value(32'h0000_0000);
      send_value(32'h0000_0000);
      send_value(32'hFFFF_FFFF);
      send_value(32'h0000_0001);
      send_value(32'h8000_0000);
      send_value(32'h0000_0005);

      for (int phase = 0; phase < 8; phase++) begin
         write_capacity(7'(PHASE_CAP[phase]));
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 20 == 0)
               idle_pct = ($urandom_range(3) == 0) ? 0 : PHASE_IDLE[phase % 4];
            if ($urandom_range(49) == 0)
               wait_drained();
            send_value(pick_value());
         end
      end

      start <= 1'b0;
      for (wait_cycles = 0; wait_cycles < 5000 && sb.pending() != 0; wait_cycles++)
         @(negedge clock);
      repeat (80) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d response words never arrived", sb.pending());
         sb.errors++;
      end

      $display("checked %0d response words: %0d numbers stored, %0d rejected",
               sb.checked, sb.stored, sb.rejected);
      $display("%0d capacity writes, final set of %0d numbers", cfg_writes, sb.count);
      if (sb.errors == 0) begin
         $display("integer_set_span_tracker_top regression: pass");
      end else begin
         $display("integer_set_span_tracker_top regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/ists_pkg.sv
hdl/ists_store.sv
hdl/ists_scan.sv
hdl/integer_set_span_tracker_top.sv
dv/span_check_pkg.sv
dv/tb.sv
